### rtl/core/nss_pkg.sv
// Package for the brute-force substring search core.
// Holds the field widths and request operation codes. It depends on nothing.
package nss_pkg;

  localparam int OP_W   = 2;
  localparam int BYTE_W = 8;
  localparam int POS_W  = 9;

  typedef logic [OP_W-1:0]   op_t;
  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [POS_W-1:0]  pos_t;

  // Request operation codes. Code 3 is unused and ignored.
  localparam op_t OP_LOAD_TEXT    = 2'd0;
  localparam op_t OP_LOAD_PATTERN = 2'd1;
  localparam op_t OP_SEARCH       = 2'd2;

endpackage

### rtl/core/nss_if.sv
// Handshake channels of the substring search core: request and result.
// Depends on nss_pkg for the payload types.
interface nss_in_if;
  import nss_pkg::*;
  logic  valid;
  logic  ready;
  op_t   op;
  byte_t data_byte;
  logic  first;
  pos_t  start_pos;

  modport source (output valid, output op, output data_byte, output first,
                  output start_pos, input ready);
  modport sink   (input valid, input op, input data_byte, input first,
                  input start_pos, output ready);
endinterface

interface nss_out_if;
  import nss_pkg::*;
  logic valid;
  logic ready;
  logic found;
  pos_t match_pos;

  modport source (output valid, output found, output match_pos, input ready);
  modport sink   (input valid, input found, input match_pos, output ready);
endinterface

### rtl/core/naive_substring_search_core.sv
// Top level of the brute-force substring search core.
// Depends on nss_pkg and on the nss_in_if / nss_out_if channel interfaces.
// Holds the text and pattern memories and the search sequencer.

// A load request (text or pattern byte) is taken whenever the sequencer is
// idle, and loads may follow each other every cycle while it stays idle, also
// while a search result waits at the output. A search request holds the
// request channel until its result enters the result register. A window that
// does not fit in the text ends the search with a miss at its fit check. For a
// window that fits, the fit check state S_CHECK also issues the registered
// read of the first text and pattern bytes, so S_CMP compares them next, and
// every later byte passes S_READ for the read and S_CMP for the compare. A
// window stops at its first differing byte. The result register then frees
// the sequencer as soon as the previous result is taken.
module naive_substring_search_core #(
  parameter int TEXT_DEPTH    = 256,
  parameter int PATTERN_DEPTH = 32
) (
  input  logic clk,
  input  logic rst_n,
  nss_in_if.sink    in_ch,
  nss_out_if.source out_ch
);
  import nss_pkg::*;

  localparam int TCW = $clog2(TEXT_DEPTH + 1);
  localparam int TAW = $clog2(TEXT_DEPTH);
  localparam int PCW = $clog2(PATTERN_DEPTH + 1);
  localparam int PAW = (PATTERN_DEPTH > 1) ? $clog2(PATTERN_DEPTH) : 1;
  localparam int PW  = ((TCW > POS_W) ? TCW : POS_W) + 1;
  localparam int SW  = ((PW > PCW) ? PW : PCW) + 1;

  typedef enum logic [2:0] {S_IDLE, S_CHECK, S_READ, S_CMP, S_FINISH} state_t;

  state_t         state_r;
  logic [TCW-1:0] text_count_r;
  logic [PCW-1:0] pat_count_r;
  logic [PW-1:0]  pos0_r;
  logic [PCW-1:0] k_r;
  logic           res_found_r;
  pos_t           res_pos_r;
  logic           out_valid_r;
  logic           out_found_r;
  pos_t           out_pos_r;

  byte_t text_mem [TEXT_DEPTH];
  byte_t pat_mem  [PATTERN_DEPTH];
  byte_t text_q;
  byte_t pat_q;

  logic           accept;
  logic           text_wr;
  logic           pat_wr;
  logic [TAW-1:0] text_waddr;
  logic [PAW-1:0] pat_waddr;
  logic [TAW-1:0] text_raddr;
  logic [PAW-1:0] pat_raddr;
  logic [SW-1:0]  win_end;
  logic           win_fits;
  logic           last_byte;
  logic           search_empty;
  logic [PW-1:0]  start0;

  // Request channel is open whenever the sequencer is idle.
  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;

  // Load addressing: a first byte restarts the string at entry zero.
  assign text_waddr = in_ch.first ? '0 : TAW'(text_count_r);
  assign pat_waddr  = in_ch.first ? '0 : PAW'(pat_count_r);
  assign text_wr = accept && (in_ch.op == OP_LOAD_TEXT) &&
                   (in_ch.first || (SW'(text_count_r) < SW'(TEXT_DEPTH)));
  assign pat_wr  = accept && (in_ch.op == OP_LOAD_PATTERN) &&
                   (in_ch.first || (SW'(pat_count_r) < SW'(PATTERN_DEPTH)));

  // Search datapath: one address add, one window fit compare.
  assign text_raddr   = TAW'(SW'(pos0_r) + SW'(k_r));
  assign pat_raddr    = PAW'(k_r);
  assign win_end      = SW'(pos0_r) + SW'(pat_count_r);
  assign win_fits     = (win_end <= SW'(text_count_r));
  assign last_byte    = ((SW'(k_r) + SW'(1)) == SW'(pat_count_r));
  assign search_empty = (pat_count_r == '0) ||
                        (SW'(pat_count_r) > SW'(text_count_r));
  assign start0       = (in_ch.start_pos == '0) ? '0 :
                        (PW'(in_ch.start_pos) - PW'(1));

  // Text memory: one write port for loads, one registered read port.
  always_ff @(posedge clk) begin
    if (text_wr) begin
      text_mem[text_waddr] <= in_ch.data_byte;
    end
    text_q <= text_mem[text_raddr];
  end

  // Pattern memory: same arrangement.
  always_ff @(posedge clk) begin
    if (pat_wr) begin
      pat_mem[pat_waddr] <= in_ch.data_byte;
    end
    pat_q <= pat_mem[pat_raddr];
  end

  // Sequencer, string counts and the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      text_count_r <= '0;
      pat_count_r  <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (text_wr) begin
        text_count_r <= TCW'(SW'(text_waddr) + SW'(1));
      end else if (accept && (in_ch.op == OP_LOAD_TEXT) && in_ch.first) begin
        text_count_r <= TCW'(1);
      end
      if (pat_wr) begin
        pat_count_r <= PCW'(SW'(pat_waddr) + SW'(1));
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept && (in_ch.op == OP_SEARCH)) begin
            pos0_r <= start0;
            k_r    <= '0;
            if (search_empty) begin
              res_found_r <= 1'b0;
              res_pos_r   <= '0;
              state_r     <= S_FINISH;
            end else begin
              state_r <= S_CHECK;
            end
          end
        end
        S_CHECK: begin
          // The read of the window's first byte is issued this cycle.
          if (win_fits) begin
            state_r <= S_CMP;
          end else begin
            res_found_r <= 1'b0;
            res_pos_r   <= '0;
            state_r     <= S_FINISH;
          end
        end
        S_READ: begin
          state_r <= S_CMP;
        end
        S_CMP: begin
          if (text_q == pat_q) begin
            if (last_byte) begin
              res_found_r <= 1'b1;
              res_pos_r   <= POS_W'(SW'(pos0_r) + SW'(1));
              state_r     <= S_FINISH;
            end else begin
              k_r     <= PCW'(SW'(k_r) + SW'(1));
              state_r <= S_READ;
            end
          end else begin
            // Mismatch: slide the window by one and start over.
            pos0_r  <= PW'(SW'(pos0_r) + SW'(1));
            k_r     <= '0;
            state_r <= S_CHECK;
          end
        end
        S_FINISH: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r <= 1'b1;
            out_found_r <= res_found_r;
            out_pos_r   <= res_pos_r;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.found     = out_found_r;
  assign out_ch.match_pos = out_pos_r;

  // An empty pattern search goes straight to the result stage.
  a_empty_finish: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_ch.op == OP_SEARCH) && (pat_count_r == '0)) |=>
      (state_r == S_FINISH))
    else $error("empty pattern search did not finish at once");

  // A compare only happens inside a window that fits in the text.
  a_cmp_fits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CMP) |-> (win_fits && (SW'(k_r) < SW'(pat_count_r))))
    else $error("compare outside the text window");

  // String counts never pass their memory depth.
  a_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (SW'(text_count_r) <= SW'(TEXT_DEPTH)) &&
    (SW'(pat_count_r) <= SW'(PATTERN_DEPTH)))
    else $error("string count beyond depth");

  // A miss always reports position zero.
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_found_r) |-> (out_pos_r == '0))
    else $error("miss with nonzero position");

  // A result is never overwritten before it is taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |=> (out_valid_r && $stable(out_pos_r)))
    else $error("pending result lost");

endmodule

### dv/tb.sv
// Testbench for the brute-force substring search core.
// Uses nss_pkg and the nss_in_if / nss_out_if channels; predicts every search result
// with a shadow copy of the text and pattern strings and checks it at the output.
`timescale 1ns / 1ps

module tb;
  import nss_pkg::*;

  localparam int TB_TEXT_DEPTH    = 256;
  localparam int TB_PATTERN_DEPTH = 32;
  localparam int WATCHDOG_LIMIT   = 100000;
  localparam int DRAIN_CYCLES     = 50;
  localparam int RANDOM_REQUESTS  = 1800;
  localparam int TOTAL_REQUESTS   = 2050;

  typedef struct packed {
    logic found;
    pos_t match_pos;
  } match_t;

  logic clk = 1'b0;
  logic rst_n;

  nss_in_if  req_ch ();
  nss_out_if res_ch ();

  naive_substring_search_core #(
    .TEXT_DEPTH    (TB_TEXT_DEPTH),
    .PATTERN_DEPTH (TB_PATTERN_DEPTH)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (req_ch),
    .out_ch (res_ch)
  );

  // Shadow copy of the strings held by the core.
  byte_t       text_mem [TB_TEXT_DEPTH];
  logic [8:0]  text_len;
  byte_t       pat_mem [TB_PATTERN_DEPTH];
  logic [5:0]  pat_len;

  match_t      pending_hits[$];
  int          requests_sent;
  int          mismatches = 0;
  int          stalled_cycles;
  int          ready_hold = 0;
  bit          idling_on;

  always #1 clk = ~clk;

  // Position of the first window at or after the start that equals the pattern.
  function automatic match_t search_text(input pos_t start);
    match_t r;
    int     pos;
    int     k;
    r.found     = 1'b0;
    r.match_pos = '0;
    if (pat_len == 0 || pat_len > text_len) return r;
    pos = (start == 0) ? 1 : int'(start);
    while (pos + int'(pat_len) - 1 <= int'(text_len)) begin
      k = 0;
      while (k < int'(pat_len) && text_mem[pos - 1 + k] == pat_mem[k]) k++;
      if (k == int'(pat_len)) begin
        r.found     = 1'b1;
        r.match_pos = pos_t'(pos);
        return r;
      end
      pos++;
    end
    return r;
  endfunction

  // Updates the shadow strings, or queues the predicted result of a search, for one accepted request.
  function automatic void apply_request(input op_t op, input byte_t data, input logic first,
                                        input pos_t start);
    case (op)
      OP_LOAD_TEXT: begin
        if (first) text_len = '0;
        if (text_len < TB_TEXT_DEPTH) begin
          text_mem[text_len] = data;
          text_len++;
        end
        requests_sent++;
      end
      OP_LOAD_PATTERN: begin
        if (first) pat_len = '0;
        if (pat_len < TB_PATTERN_DEPTH) begin
          pat_mem[pat_len] = data;
          pat_len++;
        end
        requests_sent++;
      end
      OP_SEARCH: begin
        pending_hits.push_back(search_text(start));
        requests_sent++;
      end
      default: ;
    endcase
  endfunction

  // Drives one request from a falling edge and holds it until the core takes it.
  task automatic send_request(input op_t op, input byte_t data, input logic first,
                              input pos_t start);
    int gap;
    gap = (idling_on && $urandom_range(0, 5) == 0) ? $urandom_range(1, 19) : 0;
    @(negedge clk);
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.op        <= op;
    req_ch.data_byte <= data;
    req_ch.first     <= first;
    req_ch.start_pos <= start;
    do @(posedge clk); while (!req_ch.ready);
    apply_request(op, data, first, start);
  endtask

  task automatic release_channel();
    @(negedge clk);
    req_ch.valid <= 1'b0;
  endtask

  // Holds the request channel idle until every search result has come back.
  task automatic wait_all_results();
    release_channel();
    while (pending_hits.size() != 0) @(posedge clk);
  endtask

  function automatic byte_t pick_byte(input bit narrow);
    return narrow ? byte_t'(8'h61 + $urandom_range(0, 1)) : byte_t'($urandom);
  endfunction

  // Extremes of the fields, the unused op code and the empty and short cases.
  task automatic test_basic_cases();
    send_request(OP_SEARCH, 8'hFF, 1'b1, 9'd0);          // both strings empty
    send_request(OP_LOAD_TEXT, 8'h00, 1'b1, 9'h1FF);
    send_request(OP_LOAD_TEXT, 8'hFF, 1'b0, 9'd0);
    send_request(OP_LOAD_TEXT, 8'h00, 1'b0, 9'd0);
    send_request(OP_LOAD_TEXT, 8'hFF, 1'b0, 9'd0);
    send_request(OP_SEARCH, 8'h00, 1'b0, 9'd1);          // pattern still empty
    send_request(OP_LOAD_PATTERN, 8'hFF, 1'b1, 9'h1FF);
    send_request(OP_LOAD_PATTERN, 8'h00, 1'b0, 9'd0);
    send_request(OP_SEARCH, 8'h00, 1'b0, 9'd0);          // start zero acts as one
    send_request(OP_SEARCH, 8'h00, 1'b0, 9'd3);
    send_request(OP_SEARCH, 8'h00, 1'b0, 9'h1FF);        // start past the text
    send_request(OP_SEARCH, 8'h00, 1'b0, 9'd256);
    send_request(op_t'(3), 8'hFF, 1'b1, 9'h1FF);         // unused code is ignored
    send_request(OP_LOAD_PATTERN, 8'hFF, 1'b0, 9'd0);
    send_request(OP_SEARCH, 8'h00, 1'b0, 9'd1);
    send_request(OP_LOAD_TEXT, 8'h41, 1'b1, 9'd0);
    send_request(OP_SEARCH, 8'h00, 1'b0, 9'd1);          // pattern longer than text
    send_request(OP_LOAD_PATTERN, 8'h41, 1'b1, 9'd0);
    send_request(OP_SEARCH, 8'h00, 1'b0, 9'd1);
    send_request(OP_SEARCH, 8'h00, 1'b0, 9'd2);
  endtask

  // Fills both strings past capacity, then restarts each one while it is full.
  task automatic test_store_full();
    for (int i = 0; i < TB_TEXT_DEPTH + 3; i++)
      send_request(OP_LOAD_TEXT, (i < TB_TEXT_DEPTH) ? byte_t'(i) : 8'hAA, i == 0, '0);
    send_request(OP_LOAD_PATTERN, 8'hFE, 1'b1, '0);
    send_request(OP_LOAD_PATTERN, 8'hFF, 1'b0, '0);
    send_request(OP_SEARCH, '0, 1'b0, 9'd0);
    send_request(OP_LOAD_PATTERN, 8'hFF, 1'b1, '0);
    send_request(OP_LOAD_PATTERN, 8'hAA, 1'b0, '0);      // dropped bytes must not match
    send_request(OP_SEARCH, '0, 1'b0, 9'd1);
    for (int i = 0; i < TB_PATTERN_DEPTH + 1; i++)
      send_request(OP_LOAD_PATTERN, (i < TB_PATTERN_DEPTH) ? byte_t'(i + 10) : 8'h00,
                   i == 0, '0);
    send_request(OP_SEARCH, '0, 1'b0, 9'd0);
    send_request(OP_SEARCH, '0, 1'b0, 9'd12);
    send_request(OP_LOAD_TEXT, 8'h07, 1'b1, '0);         // restart of a full text
    send_request(OP_SEARCH, '0, 1'b0, 9'd1);
    send_request(OP_LOAD_PATTERN, 8'h07, 1'b1, '0);      // restart of a full pattern
    send_request(OP_SEARCH, '0, 1'b0, 9'd1);
  endtask

  // One load-and-search sequence with random content, or a short burst of noise.
  task automatic run_session();
    int    tlen;
    int    plen;
    int    ofs;
    bit    narrow;
    bit    copy;
    byte_t b;
    narrow = ($urandom_range(0, 3) != 0);
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 6))
        send_request(op_t'($urandom_range(0, 3)), byte_t'($urandom), 1'($urandom),
                     pos_t'($urandom));
      return;
    end
    // Most texts restart on their first byte; some are appended to the old one.
    tlen = ($urandom_range(0, 19) == 0) ? $urandom_range(200, 262) : $urandom_range(1, 24);
    for (int i = 0; i < tlen; i++)
      send_request(OP_LOAD_TEXT, pick_byte(narrow), (i == 0) && ($urandom_range(0, 4) != 0),
                   pos_t'($urandom));
    // The pattern is often cut from the text so that matches are common.
    if ($urandom_range(0, 7) != 0) begin
      plen = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 5);
      copy = ($urandom_range(0, 1) == 1);
      ofs  = (text_len == 0) ? 0 : $urandom_range(0, int'(text_len) - 1);
      for (int i = 0; i < plen; i++) begin
        b = (copy && ofs + i < int'(text_len)) ? text_mem[ofs + i] : pick_byte(narrow);
        send_request(OP_LOAD_PATTERN, b, i == 0, pos_t'($urandom));
      end
    end
    repeat ($urandom_range(1, 4))
      send_request(OP_SEARCH, byte_t'($urandom), 1'($urandom),
                   ($urandom_range(0, 4) == 0) ? pos_t'($urandom)
                                               : pos_t'($urandom_range(0, int'(text_len) + 1)));
  endtask

  task automatic test_random_sessions();
    int sessions;
    sessions = 0;
    while (requests_sent < RANDOM_REQUESTS) begin
      idling_on = ($urandom_range(0, 3) != 0);
      run_session();
      sessions++;
      if (sessions == 5 || $urandom_range(0, 29) == 0) wait_all_results();
    end
  endtask

  // Closing stretch with both sides running flat out.
  task automatic test_steady_stream();
    idling_on = 1'b0;
    while (requests_sent < TOTAL_REQUESTS) run_session();
  endtask

  // Result sink: random bursts of back-pressure while idling is on.
  always @(negedge clk) begin
    if (!rst_n) begin
      res_ch.ready <= 1'b0;
    end else if (ready_hold != 0) begin
      ready_hold = ready_hold - 1;
    end else if (idling_on && $urandom_range(0, 7) == 0) begin
      res_ch.ready <= 1'b0;
      ready_hold = $urandom_range(1, 19) - 1;
    end else begin
      res_ch.ready <= 1'b1;
    end
  end

  // Compares each search result with the oldest prediction.
  always @(posedge clk) begin : check_results
    match_t got;
    match_t want;
    if (rst_n && res_ch.valid && res_ch.ready) begin
      got.found     = res_ch.found;
      got.match_pos = res_ch.match_pos;
      if (pending_hits.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: found=%0b match_pos=%0d", got.found, got.match_pos);
      end else begin
        want = pending_hits.pop_front();
        if (got.found !== want.found || got.match_pos !== want.match_pos) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected found=%0b match_pos=%0d, got found=%0b match_pos=%0d",
                     want.found, want.match_pos, got.found, got.match_pos);
        end
      end
    end
  end

  // Ends the run when neither channel has moved for too long.
  always @(posedge clk) begin
    if (!rst_n || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      stalled_cycles <= 0;
    end else if (stalled_cycles == WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      stalled_cycles <= stalled_cycles + 1;
    end
  end

  initial begin
    rst_n            = 1'b0;
    idling_on        = 1'b0;
    requests_sent    = 0;
    text_len         = '0;
    pat_len          = '0;
    req_ch.valid     <= 1'b0;
    req_ch.op        <= OP_LOAD_TEXT;
    req_ch.data_byte <= '0;
    req_ch.first     <= 1'b0;
    req_ch.start_pos <= '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    idling_on = 1'b1;
    test_basic_cases();
    test_store_full();
    test_random_sessions();
    test_steady_stream();

    wait_all_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_hits.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### naive_substring_search_core.f
rtl/core/nss_pkg.sv
rtl/core/nss_if.sv
rtl/core/naive_substring_search_core.sv
dv/tb.sv
